// ----- rtl/swrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrt_pkg
// Shared types, codes and constants for the sliding window receive tracker.
// ----------------------------------------------------------------------------
package swrt_pkg;

    localparam logic [9:0] PLEN_MAX   = 10'd548;
    localparam logic [9:0] PLEN_MIN   = 10'd12;
    localparam logic [7:0] HDR_WORDS_MIN = 8'd3;

    localparam logic [1:0] CFG_WINDOW  = 2'd0;
    localparam logic [1:0] CFG_VERSION = 2'd1;
    localparam logic [1:0] CFG_INITSEQ = 2'd2;
    localparam logic [1:0] CFG_RETRY   = 2'd3;

    localparam logic [2:0] ACT_IGNORE = 3'd0;
    localparam logic [2:0] ACT_ACK    = 3'd1;
    localparam logic [2:0] ACT_INIT   = 3'd2;
    localparam logic [2:0] ACT_STOP   = 3'd3;
    localparam logic [2:0] ACT_GIVEUP = 3'd4;

    localparam logic [7:0] MSG_SEND = 8'd8;
    localparam logic [7:0] MSG_INIT = 8'd2;
    localparam logic [7:0] MSG_STOP = 8'd4;
    localparam logic [7:0] MSG_NONE = 8'd0;

    localparam logic [1:0] VER_FIXED = 2'd1;

    localparam logic [15:0] WINDOW_RST = 16'd65535;
    localparam logic [4:0]  RETRY_RST  = 5'd30;
    localparam logic [15:0] REL_MAX    = 16'hFFFF;

    typedef struct packed {
        logic        mode;
        logic [7:0]  msg_type;
        logic [7:0]  header_words;
        logic [9:0]  packet_len;
        logic [31:0] seq_num;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] ack_seq;
        logic [31:0] highest_seq;
        logic [15:0] released_count;
        logic        finished;
    } out_item_t;

    typedef struct packed {
        logic we;
        logic wbit;
        logic re;
    } map_ctl_t;

    // x in [a,b) modulo 2^32
    function automatic logic in_span(logic [31:0] x, logic [31:0] a, logic [31:0] b);
        logic [31:0] w;
        w = b - a;
        return ((x - a) < w) && ((b - x) <= w);
    endfunction

endpackage

// ----- rtl/swrt_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrt_map
// Received-byte bitmap: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swrt_map #(
    parameter int RING_BITS = 16
) (
    input  logic                   clk,
    input  swrt_pkg::map_ctl_t     ctl,
    input  logic [RING_BITS-1:0]   waddr,
    input  logic [RING_BITS-1:0]   raddr,
    output logic                   rbit
);
    import swrt_pkg::*;

    logic mem [2**RING_BITS];
    logic rbit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= ctl.wbit;
        end
        if (ctl.re)
        begin
            rbit_reg <= mem[raddr];
        end
    end

    assign rbit = rbit_reg;

endmodule

// ----- rtl/swrt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrt_ctrl
// Window checks, mark and drain sequencer, configuration and session state.
// ----------------------------------------------------------------------------
module swrt_ctrl #(
    parameter int RING_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  swrt_pkg::in_item_t     in_item,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_wdata,
    output logic                   res_valid,
    input  logic                   res_ready,
    output swrt_pkg::out_item_t    res,
    output swrt_pkg::map_ctl_t     map_ctl,
    output logic [RING_BITS-1:0]   map_waddr,
    output logic [RING_BITS-1:0]   map_raddr,
    input  logic                   map_rbit
);
    import swrt_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_DRD   = 3'd4;
    localparam logic [2:0] S_DCHK  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [RING_BITS-1:0] CLR_LAST = '1;

    logic [2:0]           state_reg;
    logic [15:0]          win_reg;
    logic [1:0]           ver_reg;
    logic [4:0]           retry_reg;
    logic [31:0]          acked_reg;
    logic [31:0]          highest_reg;
    logic [4:0]           tmo_reg;
    logic                 mode_reg;
    logic [7:0]           msg_reg;
    logic [31:0]          seq_reg;
    logic [9:0]           dlen_reg;
    logic                 len_ok_reg;
    logic [RING_BITS-1:0] ptr_reg;
    logic [9:0]           cnt_reg;
    logic [RING_BITS-1:0] clr_reg;
    logic [2:0]           act_reg;
    logic [15:0]          rel_reg;
    logic                 fin_reg;

    // header length checks at accept
    logic [9:0]  plen_c;
    logic [7:0]  words_c;
    logic [9:0]  hdr_bytes;
    logic        accept;

    // window checks in the evaluate state
    logic [31:0] win32;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] stop_seq;
    logic        in_win;
    logic        in_acked_win;
    logic        is_send;
    logic [4:0]  tmo_inc;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    assign plen_c    = (in_item.packet_len > PLEN_MAX) ? PLEN_MAX : in_item.packet_len;
    assign words_c   = (in_item.header_words < HDR_WORDS_MIN || ver_reg == VER_FIXED)
                       ? HDR_WORDS_MIN : in_item.header_words;
    assign hdr_bytes = {words_c, 2'b00};

    assign win32        = {16'd0, win_reg};
    assign lo           = highest_reg - win32;
    assign hi           = acked_reg + win32;
    assign stop_seq     = seq_reg + {22'd0, dlen_reg};
    assign in_win       = len_ok_reg && in_span(seq_reg, lo, hi) && in_span(stop_seq, lo, hi);
    assign in_acked_win = in_span(seq_reg, acked_reg, hi) && in_span(stop_seq, acked_reg, hi);
    assign is_send      = (msg_reg == MSG_SEND) || (ver_reg == VER_FIXED && msg_reg == MSG_NONE);
    assign tmo_inc      = tmo_reg + 5'd1;

    always_comb
    begin
        map_ctl   = '0;
        map_waddr = acked_reg[RING_BITS-1:0];
        map_raddr = acked_reg[RING_BITS-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                map_ctl.we = 1'b1;
                map_waddr  = clr_reg;
            end
            S_MARK:
            begin
                map_ctl.we   = (cnt_reg != 10'd0);
                map_ctl.wbit = 1'b1;
                map_waddr    = ptr_reg;
            end
            S_DRD:
            begin
                map_ctl.re = 1'b1;
            end
            S_DCHK:
            begin
                // clear the drained mark and look one ahead
                map_ctl.we = map_rbit;
                map_ctl.re = map_rbit;
                map_raddr  = acked_reg[RING_BITS-1:0] + 1'b1;
            end
            default:
            begin
                map_ctl = '0;
            end
        endcase
    end

    assign res_valid              = (state_reg == S_DONE);
    assign res.action             = act_reg;
    assign res.ack_seq            = acked_reg;
    assign res.highest_seq        = highest_reg;
    assign res.released_count     = rel_reg;
    assign res.finished           = fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            win_reg     <= WINDOW_RST;
            ver_reg     <= VER_FIXED;
            retry_reg   <= RETRY_RST;
            acked_reg   <= '0;
            highest_reg <= '0;
            tmo_reg     <= '0;
            clr_reg     <= '0;
            mode_reg    <= 1'b0;
            msg_reg     <= '0;
            seq_reg     <= '0;
            dlen_reg    <= '0;
            len_ok_reg  <= 1'b0;
            ptr_reg     <= '0;
            cnt_reg     <= '0;
            act_reg     <= ACT_IGNORE;
            rel_reg     <= '0;
            fin_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_INITSEQ)
            begin
                // new session: reload pointers and sweep the bitmap
                acked_reg   <= cfg_wdata;
                highest_reg <= cfg_wdata;
                tmo_reg     <= '0;
                clr_reg     <= '0;
                state_reg   <= S_CLEAR;
            end
            else
            begin
                unique case (state_reg)
                    S_CLEAR:
                    begin
                        clr_reg <= clr_reg + 1'b1;
                        if (clr_reg == CLR_LAST)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    S_IDLE:
                    begin
                        if (accept)
                        begin
                            mode_reg   <= in_item.mode;
                            msg_reg    <= in_item.msg_type;
                            seq_reg    <= in_item.seq_num;
                            dlen_reg   <= plen_c - hdr_bytes;
                            len_ok_reg <= (plen_c >= PLEN_MIN) && (plen_c >= hdr_bytes);
                            state_reg  <= S_EVAL;
                        end
                    end
                    S_EVAL:
                    begin
                        rel_reg   <= '0;
                        fin_reg   <= 1'b0;
                        act_reg   <= ACT_IGNORE;
                        state_reg <= S_DONE;
                        if (mode_reg)
                        begin
                            if (tmo_inc == retry_reg)
                            begin
                                act_reg <= ACT_GIVEUP;
                                tmo_reg <= '0;
                            end
                            else
                            begin
                                act_reg <= ACT_ACK;
                                tmo_reg <= tmo_inc;
                            end
                        end
                        else if (in_win)
                        begin
                            priority if (msg_reg == MSG_STOP)
                            begin
                                act_reg <= ACT_STOP;
                                fin_reg <= (highest_reg == acked_reg);
                                tmo_reg <= '0;
                            end
                            else if (is_send)
                            begin
                                act_reg <= ACT_ACK;
                                tmo_reg <= '0;
                                if (in_acked_win)
                                begin
                                    if (!in_span(stop_seq, acked_reg, highest_reg))
                                    begin
                                        highest_reg <= stop_seq;
                                    end
                                    ptr_reg   <= seq_reg[RING_BITS-1:0];
                                    cnt_reg   <= dlen_reg;
                                    state_reg <= S_MARK;
                                end
                            end
                            else if (msg_reg == MSG_INIT)
                            begin
                                act_reg <= ACT_INIT;
                                tmo_reg <= '0;
                            end
                            else
                            begin
                                act_reg <= ACT_IGNORE;
                            end
                        end
                    end
                    S_MARK:
                    begin
                        if (cnt_reg != 10'd0)
                        begin
                            ptr_reg <= ptr_reg + 1'b1;
                            cnt_reg <= cnt_reg - 10'd1;
                        end
                        else
                        begin
                            state_reg <= S_DRD;
                        end
                    end
                    S_DRD:
                    begin
                        state_reg <= S_DCHK;
                    end
                    S_DCHK:
                    begin
                        if (map_rbit)
                        begin
                            acked_reg <= acked_reg + 32'd1;
                            if (rel_reg != REL_MAX)
                            begin
                                rel_reg <= rel_reg + 16'd1;
                            end
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    S_DONE:
                    begin
                        if (res_ready)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WINDOW:  win_reg   <= cfg_wdata[15:0];
                    CFG_VERSION: ver_reg   <= cfg_wdata[1:0];
                    CFG_RETRY:   retry_reg <= cfg_wdata[4:0];
                    CFG_INITSEQ:
                    begin
                        // session reload handled above
                    end
                endcase
            end
        end
    end

endmodule

// ----- rtl/sliding_window_receive_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_receive_tracker
// Receiver-side sequence window tracker with a received-byte bitmap.
// ----------------------------------------------------------------------------
// Items are handled one at a time; the bitmap memory (one entry per cycle)
// sets the pace. A timeout tick or a rejected header goes from accept
// through the evaluate and done states to the result. An accepted send
// header in the acked window first marks each payload byte, then drains
// marked bytes from the ack pointer. After reset and after every initial_seq
// write the bitmap is swept clear, and in_stall is high during the sweep.
// A finished result waits in the output register, so the next item is
// accepted while it is pending.
module sliding_window_receive_tracker #(
    parameter int RING_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  swrt_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output swrt_pkg::out_item_t  out_item,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_wdata
);
    import swrt_pkg::*;

    map_ctl_t             map_ctl;
    logic [RING_BITS-1:0] map_waddr;
    logic [RING_BITS-1:0] map_raddr;
    logic                 map_rbit;
    logic                 res_valid;
    logic                 res_ready;
    out_item_t            res;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;

    swrt_ctrl #(.RING_BITS(RING_BITS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .map_ctl   (map_ctl),
        .map_waddr (map_waddr),
        .map_raddr (map_raddr),
        .map_rbit  (map_rbit)
    );

    swrt_map #(.RING_BITS(RING_BITS)) u_map (
        .clk   (clk),
        .ctl   (map_ctl),
        .waddr (map_waddr),
        .raddr (map_raddr),
        .rbit  (map_rbit)
    );

    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- rtl/swrt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrt_checker
// Port-level checks on the sliding window receive tracker.
// ----------------------------------------------------------------------------
module swrt_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input swrt_pkg::out_item_t  out_item
);
    import swrt_pkg::*;

    // a held result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

    // one item at a time: busy right after a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken while item in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.action != ACT_ACK |-> out_item.released_count == 16'd0)
    else $error("bytes released without a send ack");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.finished
        |-> out_item.action == ACT_STOP && out_item.ack_seq == out_item.highest_seq)
    else $error("finished without stop at window end");

endmodule

bind sliding_window_receive_tracker swrt_checker u_swrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
